/* sv/pdcs_pkg.sv */
package pdcs_pkg;

    localparam int TIME_W  = 32;
    localparam int THR_W   = 16;
    localparam int TALLY_W = 16;
    localparam int TOTAL_W = TALLY_W + 1;
    localparam int SUM_W   = TIME_W + 1;

    // One quotient bit is produced per divider step.
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(500);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    localparam logic KIND_PRESS  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [TALLY_W-1:0] tally_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [SUM_W-1:0]   sum_t;

endpackage

/* sv/pdcs_if.sv */
interface pdcs_req_if import pdcs_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  req_type;
    logic  button_level;
    time_t now_ms;

    modport source (output valid, req_type, button_level, now_ms, input ready);
    modport sink (input valid, req_type, button_level, now_ms, output ready);
endinterface

interface pdcs_res_if import pdcs_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   result_kind;
    time_t  press_duration_ms;
    logic   press_is_short;
    total_t total_count;
    tally_t short_count;
    tally_t long_count;
    time_t  average_ms;

    modport source (output valid, result_kind, press_duration_ms, press_is_short,
                    total_count, short_count, long_count, average_ms, input ready);
    modport sink (input valid, result_kind, press_duration_ms, press_is_short,
                  total_count, short_count, long_count, average_ms, output ready);
endinterface

/* sv/pdcs_div.sv */
module pdcs_div
    import pdcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sum_t               dividend,
    input  total_t             divisor,
    output logic               done,
    output sum_t               quotient
);

    // Restoring division, one quotient bit per cycle.
    sum_t                 quo_reg,  quo_next;
    total_t               rem_reg,  rem_next;
    total_t               dvs_reg,  dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [TOTAL_W:0] shifted;
    logic [TOTAL_W:0] trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[TOTAL_W])
            begin
                rem_next = trial[TOTAL_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[TOTAL_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/press_duration_classifier_stats.sv */
// Press duration classifier with windowed statistics.
//
// Requests arrive on the samples channel (valid/ready). A button sample
// carries the sampled level and a millisecond timestamp; a rising edge starts
// a press and a falling edge during a press produces one press result on the
// results channel with its duration and short/long class. A report request
// produces one report result with the short, long and total counts and the
// truncated average duration, and then clears the statistics.
//
// The block handles one request at a time. A sample passes through the edge
// state, and the classify and emit states when it ends a press; a report
// waits on the restoring divider, one quotient bit per cycle over a 33-bit
// dividend. A finished result sits in an output register, so a new request
// is taken while it waits; if the receiver stalls and a second result is
// ready, the sequencer holds in S_EMIT until the output register frees up.
//
// The user writes the threshold register through cfg_wr_en/cfg_wr_data only
// while the block is idle; the block does not enforce this. Reset sets the
// threshold to 500 ms and clears press tracking, tallies, sums, output valid.
module press_duration_classifier_stats
    import pdcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [THR_W-1:0] cfg_wr_data,
    pdcs_req_if.sink         samples,
    pdcs_res_if.source       results
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EDGE  = 3'd1;
    localparam logic [2:0] S_CLASS = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;

    // Threshold register and press tracking state.
    logic [THR_W-1:0] thr_reg,        thr_next;
    logic             prev_level_reg, prev_level_next;
    logic             active_reg,     active_next;
    time_t            start_reg,      start_next;

    // Statistics for the current window.
    tally_t short_tally_reg, short_tally_next;
    tally_t long_tally_reg,  long_tally_next;
    time_t  short_sum_reg,   short_sum_next;
    time_t  long_sum_reg,    long_sum_next;

    // The request being worked on.
    logic  req_reg,   req_next;
    logic  level_reg, level_next;
    time_t now_reg,   now_next;

    // Result being built.
    time_t  dur_reg,       dur_next;
    logic   is_short_reg,  is_short_next;
    total_t cap_total_reg, cap_total_next;
    tally_t cap_short_reg, cap_short_next;
    tally_t cap_long_reg,  cap_long_next;
    time_t  avg_reg,       avg_next;

    // Output register.
    logic   out_valid_reg, out_valid_next;
    logic   out_kind_reg,  out_kind_next;
    time_t  out_dur_reg,   out_dur_next;
    logic   out_short_reg, out_short_next;
    total_t out_total_reg, out_total_next;
    tally_t out_scnt_reg,  out_scnt_next;
    tally_t out_lcnt_reg,  out_lcnt_next;
    time_t  out_avg_reg,   out_avg_next;

    logic   div_start;
    logic   div_done;
    sum_t   div_quotient;
    sum_t   stat_sum;
    total_t stat_total;
    sum_t   add_wide;
    time_t  add_sat;
    logic   below_thr;
    logic   out_free;

    pdcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stat_sum),
        .divisor  (stat_total),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign stat_sum   = {1'b0, short_sum_reg} + {1'b0, long_sum_reg};
    assign stat_total = {1'b0, short_tally_reg} + {1'b0, long_tally_reg};
    assign below_thr  = dur_reg < {{(TIME_W-THR_W){1'b0}}, thr_reg};
    assign out_free   = !out_valid_reg || results.ready;

    // The sum that a finished press adds to goes through one saturating adder.
    always_comb
    begin
        if (below_thr)
        begin
            add_wide = {1'b0, short_sum_reg} + {1'b0, dur_reg};
        end
        else
        begin
            add_wide = {1'b0, long_sum_reg} + {1'b0, dur_reg};
        end
        add_sat = add_wide[TIME_W] ? '1 : add_wide[TIME_W-1:0];
    end

    assign samples.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        thr_next         = cfg_wr_en ? cfg_wr_data : thr_reg;
        prev_level_next  = prev_level_reg;
        active_next      = active_reg;
        start_next       = start_reg;
        short_tally_next = short_tally_reg;
        long_tally_next  = long_tally_reg;
        short_sum_next   = short_sum_reg;
        long_sum_next    = long_sum_reg;
        req_next         = req_reg;
        level_next       = level_reg;
        now_next         = now_reg;
        dur_next         = dur_reg;
        is_short_next    = is_short_reg;
        cap_total_next   = cap_total_reg;
        cap_short_next   = cap_short_reg;
        cap_long_next    = cap_long_reg;
        avg_next         = avg_reg;
        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_dur_next     = out_dur_reg;
        out_short_next   = out_short_reg;
        out_total_next   = out_total_reg;
        out_scnt_next    = out_scnt_reg;
        out_lcnt_next    = out_lcnt_reg;
        out_avg_next     = out_avg_reg;
        div_start        = 1'b0;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    req_next   = samples.req_type;
                    level_next = samples.button_level;
                    now_next   = samples.now_ms;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (req_reg == REQ_REPORT)
                begin
                    // Snapshot the window, start the average, clear the stats.
                    cap_total_next   = stat_total;
                    cap_short_next   = short_tally_reg;
                    cap_long_next    = long_tally_reg;
                    div_start        = 1'b1;
                    short_tally_next = '0;
                    long_tally_next  = '0;
                    short_sum_next   = '0;
                    long_sum_next    = '0;
                    state_next       = S_DIV;
                end
                else if (level_reg && !prev_level_reg)
                begin
                    active_next     = 1'b1;
                    start_next      = now_reg;
                    prev_level_next = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (!level_reg && prev_level_reg && active_reg)
                begin
                    dur_next        = now_reg - start_reg;
                    active_next     = 1'b0;
                    prev_level_next = 1'b0;
                    state_next      = S_CLASS;
                end
                else
                begin
                    prev_level_next = level_reg;
                    state_next      = S_IDLE;
                end
            end
            S_CLASS:
            begin
                is_short_next = below_thr;
                if (below_thr)
                begin
                    if (short_tally_reg != '1)
                    begin
                        short_tally_next = short_tally_reg + TALLY_W'(1);
                    end
                    short_sum_next = add_sat;
                end
                else
                begin
                    if (long_tally_reg != '1)
                    begin
                        long_tally_next = long_tally_reg + TALLY_W'(1);
                    end
                    long_sum_next = add_sat;
                end
                state_next = S_EMIT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (cap_total_reg == '0)
                    begin
                        avg_next = '0;
                    end
                    else if (div_quotient[SUM_W-1])
                    begin
                        avg_next = '1;
                    end
                    else
                    begin
                        avg_next = div_quotient[TIME_W-1:0];
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (req_reg == REQ_REPORT)
                    begin
                        out_kind_next  = KIND_REPORT;
                        out_dur_next   = '0;
                        out_short_next = 1'b0;
                        out_total_next = cap_total_reg;
                        out_scnt_next  = cap_short_reg;
                        out_lcnt_next  = cap_long_reg;
                        out_avg_next   = avg_reg;
                    end
                    else
                    begin
                        out_kind_next  = KIND_PRESS;
                        out_dur_next   = dur_reg;
                        out_short_next = is_short_reg;
                        out_total_next = '0;
                        out_scnt_next  = '0;
                        out_lcnt_next  = '0;
                        out_avg_next   = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            thr_reg         <= THRESHOLD_RESET;
            prev_level_reg  <= 1'b0;
            active_reg      <= 1'b0;
            start_reg       <= '0;
            short_tally_reg <= '0;
            long_tally_reg  <= '0;
            short_sum_reg   <= '0;
            long_sum_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            thr_reg         <= thr_next;
            prev_level_reg  <= prev_level_next;
            active_reg      <= active_next;
            start_reg       <= start_next;
            short_tally_reg <= short_tally_next;
            long_tally_reg  <= long_tally_next;
            short_sum_reg   <= short_sum_next;
            long_sum_reg    <= long_sum_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        level_reg     <= level_next;
        now_reg       <= now_next;
        dur_reg       <= dur_next;
        is_short_reg  <= is_short_next;
        cap_total_reg <= cap_total_next;
        cap_short_reg <= cap_short_next;
        cap_long_reg  <= cap_long_next;
        avg_reg       <= avg_next;
        out_kind_reg  <= out_kind_next;
        out_dur_reg   <= out_dur_next;
        out_short_reg <= out_short_next;
        out_total_reg <= out_total_next;
        out_scnt_reg  <= out_scnt_next;
        out_lcnt_reg  <= out_lcnt_next;
        out_avg_reg   <= out_avg_next;
    end

    assign results.valid             = out_valid_reg;
    assign results.result_kind       = out_kind_reg;
    assign results.press_duration_ms = out_dur_reg;
    assign results.press_is_short    = out_short_reg;
    assign results.total_count       = out_total_reg;
    assign results.short_count       = out_scnt_reg;
    assign results.long_count        = out_lcnt_reg;
    assign results.average_ms        = out_avg_reg;

endmodule
